>>> rtl/core/skft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key flag table package
// Shared types, request codes and default sizes for the sorted key table.
// ----------------------------------------------------------------------------
package skft_pkg;

   localparam int KEY_W         = 64;
   localparam int DEFAULT_DEPTH = 256;

   // Request codes; the fourth code is reserved and answered with an empty result.
   localparam logic [1:0] REQ_SET     = 2'd0;
   localparam logic [1:0] REQ_SET_ALL = 2'd1;
   localparam logic [1:0] REQ_QUERY   = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [KEY_W-1:0] key;
      logic             flag_value;
   } request_type;

   typedef struct packed {
      logic hit;
      logic enabled;
      logic status;
   } response_type;

   // Memory control group from the sequencer to the storage.
   typedef struct packed {
      logic rd_en;
      logic key_we;
      logic flag_we;
   } mem_ctl_type;

endpackage
`default_nettype wire

>>> rtl/core/skft_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key flag table storage
// Key and flag memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
module skft_store #(
   parameter int TABLE_DEPTH = skft_pkg::DEFAULT_DEPTH,
   parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  wire logic                      clock,
   input  wire skft_pkg::mem_ctl_type     ctl,
   input  wire logic [IDX_W-1:0]          rd_addr,
   input  wire logic [IDX_W-1:0]          wr_addr,
   input  wire logic [skft_pkg::KEY_W-1:0] wr_key,
   input  wire logic                      wr_flag,
   output logic      [skft_pkg::KEY_W-1:0] rd_key,
   output logic                           rd_flag
);

   logic [skft_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
   logic                       flag_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (ctl.flag_we) begin
         flag_mem[wr_addr] <= wr_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_key  <= key_mem[rd_addr];
         rd_flag <= flag_mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/skft_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key flag table comparator
// The shared unsigned key compare used by every search probe.
// ----------------------------------------------------------------------------
module skft_cmp (
   input  wire logic [skft_pkg::KEY_W-1:0] stored_key,
   input  wire logic [skft_pkg::KEY_W-1:0] probe_key,
   output logic                            stored_lt,
   output logic                            stored_eq
);

   assign stored_lt = (stored_key < probe_key);
   assign stored_eq = (stored_key == probe_key);

endmodule
`default_nettype wire

>>> rtl/core/skft_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key flag table sequencer
// Runs binary search probes, ordered insert shifts and flag sweeps.
// ----------------------------------------------------------------------------
module skft_ctrl #(
   parameter int TABLE_DEPTH = skft_pkg::DEFAULT_DEPTH,
   parameter int IDX_W       = $clog2(TABLE_DEPTH),
   parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire skft_pkg::request_type      req_data,
   output logic                            busy,
   output logic                            rsp_valid,
   output skft_pkg::response_type          rsp_data,
   output skft_pkg::mem_ctl_type           ctl,
   output logic [IDX_W-1:0]                rd_addr,
   output logic [IDX_W-1:0]                wr_addr,
   output logic [skft_pkg::KEY_W-1:0]      wr_key,
   output logic                            wr_flag,
   output logic [skft_pkg::KEY_W-1:0]      probe_key,
   input  wire logic [skft_pkg::KEY_W-1:0] rd_key,
   input  wire logic                       rd_flag,
   input  wire logic                       stored_lt,
   input  wire logic                       stored_eq
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_CHECK_WAIT,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_SWEEP
   } state_type;

   state_type             state_ff, state_in;
   skft_pkg::request_type req_ff, req_in;
   logic [CNT_W-1:0]      lo_ff, lo_in;
   logic [CNT_W-1:0]      hi_ff, hi_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  found_ff, found_in;
   logic                  flag_ff, flag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   skft_pkg::response_type rsp_ff, rsp_in;

   logic [CNT_W:0]        mid_sum;
   logic [CNT_W-1:0]      mid;
   logic [CNT_W-1:0]      idx_dec;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = CNT_W'(mid_sum >> 1);
   assign idx_dec = idx_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      flag_in      = flag_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      rd_addr      = mid[IDX_W-1:0];
      wr_addr      = idx_ff[IDX_W-1:0];
      wr_key       = req_ff.key;
      wr_flag      = req_ff.flag_value;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               lo_in  = '0;
               hi_in  = count_ff;
               idx_in = '0;
               case (req_data.req_type)
                  skft_pkg::REQ_SET,
                  skft_pkg::REQ_QUERY: state_in = ST_SEARCH;
                  skft_pkg::REQ_SET_ALL: state_in = ST_SWEEP;
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{hit: 1'b0, enabled: 1'b0,
                                      status: skft_pkg::STATUS_OK};
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               ctl.rd_en = 1'b1;
               rd_addr   = mid[IDX_W-1:0];
               state_in  = ST_SEARCH_WAIT;
            end else if (lo_ff < count_ff) begin
               ctl.rd_en = 1'b1;
               rd_addr   = lo_ff[IDX_W-1:0];
               state_in  = ST_CHECK_WAIT;
            end else begin
               found_in = 1'b0;
               flag_in  = 1'b0;
               state_in = ST_DECIDE;
            end
         end
         ST_SEARCH_WAIT: begin
            if (stored_lt) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_SEARCH;
         end
         ST_CHECK_WAIT: begin
            found_in = stored_eq;
            flag_in  = rd_flag;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (req_ff.req_type == skft_pkg::REQ_QUERY) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{hit: found_ff, enabled: found_ff & flag_ff,
                                status: skft_pkg::STATUS_OK};
               state_in     = ST_IDLE;
            end else if (found_ff) begin
               ctl.flag_we  = 1'b1;
               wr_addr      = lo_ff[IDX_W-1:0];
               rsp_valid_in = 1'b1;
               rsp_in       = '{hit: 1'b1, enabled: req_ff.flag_value,
                                status: skft_pkg::STATUS_OK};
               state_in     = ST_IDLE;
            end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{hit: 1'b0, enabled: 1'b0,
                                status: skft_pkg::STATUS_FULL};
               state_in     = ST_IDLE;
            end else begin
               idx_in   = count_ff;
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (idx_ff > lo_ff) begin
               ctl.rd_en = 1'b1;
               rd_addr   = idx_dec[IDX_W-1:0];
               state_in  = ST_SHIFT_WR;
            end else begin
               // The gap has reached the insert position.
               ctl.key_we   = 1'b1;
               ctl.flag_we  = 1'b1;
               count_in     = count_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_in       = '{hit: 1'b0, enabled: req_ff.flag_value,
                                status: skft_pkg::STATUS_OK};
               state_in     = ST_IDLE;
            end
         end
         ST_SHIFT_WR: begin
            ctl.key_we  = 1'b1;
            ctl.flag_we = 1'b1;
            wr_key      = rd_key;
            wr_flag     = rd_flag;
            idx_in      = idx_dec;
            state_in    = ST_SHIFT_RD;
         end
         ST_SWEEP: begin
            if (idx_ff < count_ff) begin
               ctl.flag_we = 1'b1;
               idx_in      = idx_ff + CNT_W'(1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{hit: 1'b0, enabled: 1'b0,
                                status: skft_pkg::STATUS_OK};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      flag_ff  <= flag_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign probe_key = req_ff.key;

endmodule
`default_nettype wire

>>> rtl/core/sorted_key_flag_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key flag table
// Ordered table of 64-bit keys with one enable flag each, searched by
// binary search and kept sorted by shifting entries on insert.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                     Handshake
//   request   start, busy, req_data     taken when start is high, busy low
//   result    rsp_valid, rsp_data       one-cycle strobe, cannot be stalled
//
// A query or a set walks a binary search over the stored entries. Every
// probe is one memory read followed by one compare step. An insert then
// moves each larger entry up one place, with one read and one write each
// through the single memory port pair, and adds one final write. A set-all
// request writes one flag per cycle. A reserved request code never raises
// busy and is answered in the next cycle. The single read port of the key
// memory is shared by all of these steps.
//
// Reset clears the entry count, the sequencer and the result strobe; the
// memories are not cleared, since only entries below the count are read.
// The result strobe rises in the cycle after the sequencer finishes, and busy
// is already low in that cycle, so the next request may be taken alongside
// the strobe. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sorted_key_flag_table #(
   parameter int TABLE_DEPTH = skft_pkg::DEFAULT_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire skft_pkg::request_type  req_data,
   output logic                        busy,
   output logic                        rsp_valid,
   output skft_pkg::response_type      rsp_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   skft_pkg::mem_ctl_type      ctl;
   logic [IDX_W-1:0]           rd_addr;
   logic [IDX_W-1:0]           wr_addr;
   logic [skft_pkg::KEY_W-1:0] wr_key;
   logic                       wr_flag;
   logic [skft_pkg::KEY_W-1:0] rd_key;
   logic                       rd_flag;
   logic [skft_pkg::KEY_W-1:0] probe_key;
   logic                       stored_lt;
   logic                       stored_eq;

   // The sequencer owns the search bounds, the entry count and the result.
   skft_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_key    (wr_key),
      .wr_flag   (wr_flag),
      .probe_key (probe_key),
      .rd_key    (rd_key),
      .rd_flag   (rd_flag),
      .stored_lt (stored_lt),
      .stored_eq (stored_eq)
   );

   // Key and flag storage; read data is registered and appears in the cycle after the address.
   skft_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock   (clock),
      .ctl     (ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .wr_flag (wr_flag),
      .rd_key  (rd_key),
      .rd_flag (rd_flag)
   );

   // The one comparator shared by every search probe and the final match check.
   skft_cmp u_cmp (
      .stored_key (rd_key),
      .probe_key  (probe_key),
      .stored_lt  (stored_lt),
      .stored_eq  (stored_eq)
   );

endmodule
`default_nettype wire
